// ===== design/stsau_pkg.sv =====
// ----------------------------------------------------------------------------
// Symmetric triplet scatter-accumulate package
// Sizes, action and status codes and the saturating Q16.16 adder.
// ----------------------------------------------------------------------------
package stsau_pkg;

  localparam int MAX_DIM = 64;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int DIM_W   = 7;
  localparam int DATA_W  = 32;
  localparam int PROD_W  = 2 * DIM_W;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              sat;
  } sat_sum_t;

  function automatic sat_sum_t sat_add(input logic [DATA_W-1:0] a,
                                       input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    sat_sum_t        r;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    r.sat = s[DATA_W] ^ s[DATA_W-1];
    if (!r.sat) begin
      r.value = s[DATA_W-1:0];
    end else if (s[DATA_W]) begin
      r.value = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r.value = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== design/stsau_ram.sv =====
// ----------------------------------------------------------------------------
// Matrix store
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module stsau_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [stsau_pkg::ADDR_W-1:0]  waddr,
  input  logic [stsau_pkg::DATA_W-1:0]  wdata,
  input  logic [stsau_pkg::ADDR_W-1:0]  raddr,
  output logic [stsau_pkg::DATA_W-1:0]  rdata
);

  logic [stsau_pkg::DATA_W-1:0] mem [stsau_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/symmetric_triplet_scatter_accumulate_unit.sv =====
// ----------------------------------------------------------------------------
// Symmetric triplet scatter-accumulate unit
// Dense square matrix store built up from triplets, with clear and read.
// ----------------------------------------------------------------------------
// Each request transaction gives exactly one response transaction. After reset
// the store is swept to zero, one word a cycle over all MAX_DIM*MAX_DIM words
// (4096), and no request is taken meanwhile. All work goes through the single
// store with one read and one write per cycle; an add off the diagonal writes
// both the word and its mirror. One request is in the unit at a time; the
// response register lets the next request be accepted while a response still
// waits.
module symmetric_triplet_scatter_accumulate_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                matrix_dim_we,
  input  logic [stsau_pkg::DIM_W-1:0]         matrix_dim,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic [1:0]                          action,
  input  logic [stsau_pkg::DIM_W-1:0]         row_index,
  input  logic [stsau_pkg::DIM_W-1:0]         col_index,
  input  logic signed [stsau_pkg::DATA_W-1:0] triplet_value,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic signed [stsau_pkg::DATA_W-1:0] read_value,
  output logic [1:0]                          status
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_PREP, S_CLEAR, S_RD1, S_WR1, S_WR2, S_RD, S_RDW, S_OUT
  } state_t;

  state_t                          state;
  logic [stsau_pkg::DIM_W-1:0]     dim_reg;
  stsau_pkg::action_t              act;
  logic [stsau_pkg::DIM_W-1:0]     row;
  logic [stsau_pkg::DIM_W-1:0]     col;
  logic [stsau_pkg::DATA_W-1:0]    val;
  logic [stsau_pkg::ADDR_W-1:0]    addr_mir;
  logic [stsau_pkg::ADDR_W-1:0]    addr_dir;
  logic [stsau_pkg::ADDR_W-1:0]    cnt;
  logic [stsau_pkg::ADDR_W-1:0]    last;
  logic                            diag;
  logic                            sat;
  logic [stsau_pkg::DATA_W-1:0]    res_value;
  stsau_pkg::status_t              res_status;

  logic [stsau_pkg::DIM_W-1:0]     d_eff;
  logic [stsau_pkg::DIM_W-1:0]     rm1;
  logic [stsau_pkg::DIM_W-1:0]     cm1;
  logic                            in_rng;
  logic [stsau_pkg::PROD_W-1:0]    pos_mir;
  logic [stsau_pkg::PROD_W-1:0]    pos_dir;
  logic [stsau_pkg::PROD_W-1:0]    area;

  logic                            mem_we;
  logic [stsau_pkg::ADDR_W-1:0]    mem_waddr;
  logic [stsau_pkg::DATA_W-1:0]    mem_wdata;
  logic [stsau_pkg::ADDR_W-1:0]    mem_raddr;
  logic [stsau_pkg::DATA_W-1:0]    mem_rdata;
  stsau_pkg::sat_sum_t             sum;

  stsau_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign req_ready = (state == S_IDLE);

  always_comb begin
    if (dim_reg == '0) begin
      d_eff = stsau_pkg::DIM_W'(1);
    end else if (int'(dim_reg) > stsau_pkg::MAX_DIM) begin
      d_eff = stsau_pkg::DIM_W'(stsau_pkg::MAX_DIM);
    end else begin
      d_eff = dim_reg;
    end
    rm1     = row - stsau_pkg::DIM_W'(1);
    cm1     = col - stsau_pkg::DIM_W'(1);
    in_rng  = (row != '0) && (row <= d_eff) && (col != '0) && (col <= d_eff);
    pos_mir = stsau_pkg::PROD_W'(cm1) * stsau_pkg::PROD_W'(d_eff)
              + stsau_pkg::PROD_W'(rm1);
    pos_dir = stsau_pkg::PROD_W'(rm1) * stsau_pkg::PROD_W'(d_eff)
              + stsau_pkg::PROD_W'(cm1);
    area    = stsau_pkg::PROD_W'(d_eff) * stsau_pkg::PROD_W'(d_eff);
  end

  always_comb begin
    sum       = stsau_pkg::sat_add(mem_rdata, val);
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = '0;
    mem_raddr = addr_dir;
    unique case (state)
      S_INIT, S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_RD1: begin
        mem_raddr = addr_mir;
      end
      S_WR1: begin
        mem_we    = 1'b1;
        mem_waddr = addr_mir;
        mem_wdata = sum.value;
      end
      S_WR2: begin
        mem_we    = 1'b1;
        mem_waddr = addr_dir;
        mem_wdata = sum.value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      dim_reg   <= stsau_pkg::DIM_RESET;
      cnt       <= '0;
      last      <= stsau_pkg::ADDR_W'(stsau_pkg::DEPTH - 1);
      rsp_valid <= 1'b0;
    end else begin
      if (matrix_dim_we) begin
        dim_reg <= matrix_dim;
      end
      if (rsp_valid && rsp_ready && (state != S_OUT)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          if (cnt == last) begin
            state <= S_IDLE;
          end else begin
            cnt <= cnt + stsau_pkg::ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            act   <= stsau_pkg::action_t'(action);
            row   <= row_index;
            col   <= col_index;
            val   <= triplet_value;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          addr_mir   <= stsau_pkg::ADDR_W'(pos_mir);
          addr_dir   <= stsau_pkg::ADDR_W'(pos_dir);
          diag       <= (row == col);
          res_value  <= '0;
          res_status <= stsau_pkg::ST_OK;
          unique case (act)
            stsau_pkg::ACT_CLEAR: begin
              cnt   <= '0;
              last  <= stsau_pkg::ADDR_W'(area - stsau_pkg::PROD_W'(1));
              state <= S_CLEAR;
            end
            stsau_pkg::ACT_ADD: begin
              if (in_rng) begin
                state <= S_RD1;
              end else begin
                res_status <= stsau_pkg::ST_RANGE;
                state      <= S_OUT;
              end
            end
            stsau_pkg::ACT_READ: begin
              if (in_rng) begin
                state <= S_RD;
              end else begin
                res_status <= stsau_pkg::ST_RANGE;
                state      <= S_OUT;
              end
            end
            default: begin
              state <= S_OUT;
            end
          endcase
        end
        S_CLEAR: begin
          if (cnt == last) begin
            state <= S_OUT;
          end else begin
            cnt <= cnt + stsau_pkg::ADDR_W'(1);
          end
        end
        S_RD1: begin
          state <= S_WR1;
        end
        S_WR1: begin
          sat <= sum.sat;
          if (diag) begin
            if (sum.sat) begin
              res_status <= stsau_pkg::ST_SAT;
            end
            state <= S_OUT;
          end else begin
            state <= S_WR2;
          end
        end
        S_WR2: begin
          if (sum.sat || sat) begin
            res_status <= stsau_pkg::ST_SAT;
          end
          state <= S_OUT;
        end
        S_RD: begin
          state <= S_RDW;
        end
        S_RDW: begin
          res_value <= mem_rdata;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid  <= 1'b1;
            read_value <= res_value;
            status     <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
